FILE: rtl/core/i2cams_pkg.sv
// Shared constants and types for the I2C addressed memory slave core.
package i2cams_pkg;

    localparam int MEM_BYTES = 8192;
    localparam int ADDR_W    = $clog2(MEM_BYTES);

    localparam logic [15:0]       HIGH_MASK = 16'hFF00;
    localparam logic [16:0]       MEM_SIZE  = 17'(MEM_BYTES);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MEM_BYTES - 1);

    localparam logic [1:0] MODE_READ  = 2'd0;
    localparam logic [1:0] MODE_START = 2'd1;
    localparam logic [1:0] MODE_DATA  = 2'd2;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        OP_NONE,
        OP_READ,
        OP_WRITE
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
    } cmd_t;

    typedef struct packed {
        logic empty;
        logic full;
    } queue_status_t;

endpackage

FILE: rtl/core/i2cams_ram.sv
// Generic simple dual-port RAM with registered read data.
module i2cams_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/core/i2cams_front.sv
// Front end: accepts bus events, tracks the address phase and pointer, issues commands.
module i2cams_front (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [1:0]               mode,
    input  logic [7:0]               rx_byte,
    input  logic                     queue_full,
    input  logic                     clearing,
    output logic                     push,
    output i2cams_pkg::cmd_t         push_cmd
);

    logic [i2cams_pkg::ADDR_W-1:0] pointer_reg, pointer_next;
    logic                          phase_reg, phase_next;
    logic                          seen_reg, seen_next;
    logic [i2cams_pkg::ADDR_W-1:0] ptr_inc;
    logic [16:0]                   hi_addr;
    logic [16:0]                   lo_addr;
    logic [i2cams_pkg::ADDR_W-1:0] hi_clamped;
    logic [i2cams_pkg::ADDR_W-1:0] lo_clamped;

    assign in_stall = queue_full | clearing;
    assign push     = in_valid & ~in_stall;

    assign ptr_inc = (pointer_reg == i2cams_pkg::LAST_ADDR)
                   ? '0 : pointer_reg + 1'b1;

    assign hi_addr = {1'b0, {rx_byte, 8'h00} & i2cams_pkg::HIGH_MASK};
    assign lo_addr = {{(17 - i2cams_pkg::ADDR_W){1'b0}}, pointer_reg} | {9'b0, rx_byte};

    assign hi_clamped = (hi_addr >= i2cams_pkg::MEM_SIZE)
                      ? i2cams_pkg::LAST_ADDR : hi_addr[i2cams_pkg::ADDR_W-1:0];
    assign lo_clamped = (lo_addr >= i2cams_pkg::MEM_SIZE)
                      ? i2cams_pkg::LAST_ADDR : lo_addr[i2cams_pkg::ADDR_W-1:0];

    always_comb
    begin
        pointer_next  = pointer_reg;
        phase_next    = phase_reg;
        seen_next     = seen_reg;
        push_cmd.op   = i2cams_pkg::OP_NONE;
        push_cmd.addr = pointer_reg;
        push_cmd.data = rx_byte;
        unique case (mode)
            i2cams_pkg::MODE_READ:
            begin
                push_cmd.op  = i2cams_pkg::OP_READ;
                pointer_next = ptr_inc;
            end
            i2cams_pkg::MODE_START:
            begin
                seen_next  = 1'b0;
                phase_next = 1'b1;
            end
            i2cams_pkg::MODE_DATA:
            begin
                if (phase_reg)
                begin
                    if (!seen_reg)
                    begin
                        pointer_next = hi_clamped;
                        seen_next    = 1'b1;
                    end
                    else
                    begin
                        pointer_next = lo_clamped;
                        seen_next    = 1'b0;
                        phase_next   = 1'b0;
                    end
                end
                else
                begin
                    push_cmd.op  = i2cams_pkg::OP_WRITE;
                    pointer_next = ptr_inc;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pointer_reg <= '0;
            phase_reg   <= 1'b1;
            seen_reg    <= 1'b0;
        end
        else if (push)
        begin
            pointer_reg <= pointer_next;
            phase_reg   <= phase_next;
            seen_reg    <= seen_next;
        end
    end

endmodule

FILE: rtl/core/i2cams_queue.sv
// Short command queue between the front end and the memory back end.
module i2cams_queue (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    input  i2cams_pkg::cmd_t          push_cmd,
    input  logic                      pop,
    output i2cams_pkg::cmd_t          pop_cmd,
    output i2cams_pkg::queue_status_t status
);

    i2cams_pkg::cmd_t                   entry_reg [i2cams_pkg::QUEUE_DEPTH];
    logic [i2cams_pkg::QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [i2cams_pkg::QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [i2cams_pkg::QUEUE_CNT_W-1:0] count_reg, count_next;

    localparam logic [i2cams_pkg::QUEUE_PTR_W-1:0] LAST_SLOT =
        i2cams_pkg::QUEUE_PTR_W'(i2cams_pkg::QUEUE_DEPTH - 1);
    localparam logic [i2cams_pkg::QUEUE_CNT_W-1:0] FULL_COUNT =
        i2cams_pkg::QUEUE_CNT_W'(i2cams_pkg::QUEUE_DEPTH);

    assign status.empty = (count_reg == '0);
    assign status.full  = (count_reg == FULL_COUNT);
    assign pop_cmd      = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_SLOT) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_SLOT) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

FILE: rtl/core/i2cams_back.sv
// Back end: clears the memory after reset, executes commands, drives the result register.
module i2cams_back (
    input  logic                      clk,
    input  logic                      rst_n,
    input  i2cams_pkg::cmd_t          pop_cmd,
    input  i2cams_pkg::queue_status_t status,
    output logic                      pop,
    output logic                      clearing,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [7:0]                read_byte,
    output logic                      read_valid
);

    logic                          clearing_reg, clearing_next;
    logic [i2cams_pkg::ADDR_W-1:0] clr_addr_reg, clr_addr_next;
    logic                          s1_valid_reg, s1_valid_next;
    logic                          s1_read_reg;
    logic                          out_valid_reg, out_valid_next;
    logic [7:0]                    read_byte_reg;
    logic                          read_valid_reg;
    logic                          out_free;
    logic                          ram_we;
    logic [i2cams_pkg::ADDR_W-1:0] ram_waddr;
    logic [7:0]                    ram_wdata;
    logic                          ram_re;
    logic [7:0]                    ram_rdata;

    assign clearing = clearing_reg;
    assign out_free = ~out_valid_reg | ~out_stall;
    assign pop      = ~clearing_reg & ~status.empty & (~s1_valid_reg | out_free);

    assign ram_we    = clearing_reg | (pop & (pop_cmd.op == i2cams_pkg::OP_WRITE));
    assign ram_waddr = clearing_reg ? clr_addr_reg : pop_cmd.addr;
    assign ram_wdata = clearing_reg ? 8'h00 : pop_cmd.data;
    assign ram_re    = pop & (pop_cmd.op == i2cams_pkg::OP_READ);

    i2cams_ram #(
        .WIDTH (8),
        .DEPTH (i2cams_pkg::MEM_BYTES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (pop_cmd.addr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        clearing_next  = clearing_reg;
        clr_addr_next  = clr_addr_reg;
        s1_valid_next  = s1_valid_reg;
        out_valid_next = out_valid_reg;
        if (clearing_reg)
        begin
            clr_addr_next = clr_addr_reg + 1'b1;
            if (clr_addr_reg == i2cams_pkg::LAST_ADDR)
            begin
                clearing_next = 1'b0;
            end
        end
        if (out_free)
        begin
            out_valid_next = s1_valid_reg;
        end
        if (pop)
        begin
            s1_valid_next = 1'b1;
        end
        else if (out_free)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg  <= 1'b1;
            clr_addr_reg  <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            clearing_reg  <= clearing_next;
            clr_addr_reg  <= clr_addr_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            s1_read_reg <= (pop_cmd.op == i2cams_pkg::OP_READ);
        end
        if (out_free && s1_valid_reg)
        begin
            read_byte_reg  <= s1_read_reg ? ram_rdata : 8'h00;
            read_valid_reg <= s1_read_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign read_byte  = read_byte_reg;
    assign read_valid = read_valid_reg;

endmodule

FILE: rtl/core/i2cams_core.sv
// Top level of the I2C addressed memory slave core.
// Each request is a bus event (read request, write start, data byte) and yields exactly
// one result, in order: the memory byte with read_valid set for a read request, zeros
// otherwise. A front end keeps the pointer and address phase and takes one request per
// cycle while in_stall is low; a two-entry command queue feeds the memory back end, which
// does one RAM access per cycle, so with out_stall low the sustained rate is one request
// per clock. Each result passes through the queue, the RAM read stage and the result
// register to out_valid. After reset the back end clears all MEM_BYTES (8192) bytes of
// memory, one byte a cycle, and in_stall stays high until it is done.
module i2c_addressed_memory_slave_core (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] mode,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] read_byte,
    output logic       read_valid
);

    i2cams_pkg::cmd_t          push_cmd;
    i2cams_pkg::cmd_t          pop_cmd;
    i2cams_pkg::queue_status_t status;
    logic                      push;
    logic                      pop;
    logic                      clearing;

    i2cams_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .mode       (mode),
        .rx_byte    (rx_byte),
        .queue_full (status.full),
        .clearing   (clearing),
        .push       (push),
        .push_cmd   (push_cmd)
    );

    i2cams_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .pop_cmd  (pop_cmd),
        .status   (status)
    );

    i2cams_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .pop_cmd    (pop_cmd),
        .status     (status),
        .pop        (pop),
        .clearing   (clearing),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .read_byte  (read_byte),
        .read_valid (read_valid)
    );

endmodule
